[design/semf_pkg.sv]
// shared widths, defaults and controller/datapath interface types
`timescale 1ns / 1ps

package semf_pkg;

    localparam int CODE_W          = 16;
    localparam int SAMPLE_W        = 12;
    localparam int MAX_POINTS_DEF  = 1024;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // store the point now on the inputs
        logic mid_calc;  // form the mid level, rewind the walk
        logic rd_en;     // read the next stored point
        logic emit;      // latch the summary and clear the sweep
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic rd_last;   // current read address is the last stored point
    } t_status;

endpackage

[design/sweep_extreme_midpoint_finder.sv]
// top level of the sweep extreme and mid point finder
`timescale 1ns / 1ps

// Sweep points (drive code and ADC sample) are taken one per cycle while busy
// is low; a transfer happens at a rising edge with start high and busy low.
// The block stores up to MAX_POINTS points and tracks the first strict maximum
// and first strict minimum sample with their codes; points beyond capacity are
// dropped and flagged. The transfer marked last_point starts a walk over the
// stored points: busy is high while the block forms the mid level, reads each
// stored point through the single read port of the point memory, one point a
// cycle, then drains the registered read and latches the summary. The summary
// appears on the o_ ports for exactly one cycle with o_valid high, in the cycle
// busy falls; the receiver cannot stall it, so it must capture it then. A new
// sweep may start in that same cycle.

module sweep_extreme_midpoint_finder
    import semf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CODE_W-1:0]   i_sweep_code,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_last_point,
    output logic                o_valid,
    output logic [CODE_W-1:0]   o_max_code,
    output logic [CODE_W-1:0]   o_min_code,
    output logic [CODE_W-1:0]   o_mid_code,
    output logic [SAMPLE_W-1:0] o_max_sample,
    output logic [SAMPLE_W-1:0] o_min_sample,
    output logic [SAMPLE_W-1:0] o_mid_sample,
    output logic                o_mid_found,
    output logic                o_overflowed
);

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    // sequencer: accepts points, runs the walk, strobes the result
    semf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_last_point (i_last_point),
        .i_status     (status),
        .o_cmd        (cmd),
        .busy         (busy),
        .o_valid      (o_valid)
    );

    // datapath: point memory, extremes, distance compare, summary registers
    semf_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sweep_code (i_sweep_code),
        .i_sample     (i_sample),
        .o_status     (status),
        .o_max_code   (o_max_code),
        .o_min_code   (o_min_code),
        .o_mid_code   (o_mid_code),
        .o_max_sample (o_max_sample),
        .o_min_sample (o_min_sample),
        .o_mid_sample (o_mid_sample),
        .o_mid_found  (o_mid_found),
        .o_overflowed (o_overflowed)
    );

endmodule

[design/semf_ctrl.sv]
// sequencing state machine: load, mid level, walk, drain, emit
`timescale 1ns / 1ps

module semf_ctrl
    import semf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_last_point,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy,
    output logic    o_valid
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MID,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_valid, n_valid;
    logic   accept;

    assign accept = start && !r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load = accept;
                if (accept && i_last_point) begin
                    n_state = ST_MID;
                end
            end
            ST_MID: begin
                o_cmd.mid_calc = 1'b1;
                n_state        = ST_WALK;
            end
            ST_WALK: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.rd_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
        n_busy  = (n_state != ST_LOAD);
        n_valid = (r_state == ST_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_valid;

endmodule

[design/semf_dp.sv]
// point store, extreme tracking and mid point search datapath
`timescale 1ns / 1ps

module semf_dp
    import semf_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [CODE_W-1:0]   i_sweep_code,
    input  logic [SAMPLE_W-1:0] i_sample,
    output t_status             o_status,
    output logic [CODE_W-1:0]   o_max_code,
    output logic [CODE_W-1:0]   o_min_code,
    output logic [CODE_W-1:0]   o_mid_code,
    output logic [SAMPLE_W-1:0] o_max_sample,
    output logic [SAMPLE_W-1:0] o_min_sample,
    output logic [SAMPLE_W-1:0] o_mid_sample,
    output logic                o_mid_found,
    output logic                o_overflowed
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = CODE_W + SAMPLE_W;

    logic [DW-1:0]       r_mem [MAX_POINTS];

    logic [CW-1:0]       r_count;
    logic [SAMPLE_W-1:0] r_hi_sample, r_lo_sample;
    logic [CODE_W-1:0]   r_hi_code, r_lo_code;
    logic                r_dropped;
    logic                full;

    logic [SAMPLE_W-1:0] r_mid_level;
    logic [AW-1:0]       r_addr;
    logic                r_rd_vld, r_rd_first;
    logic [DW-1:0]       r_rd_data;

    logic [SAMPLE_W-1:0] r_best_dev;
    logic [CODE_W-1:0]   r_pick_code;
    logic [SAMPLE_W-1:0] r_pick_sample;
    logic                r_found, r_stop;

    logic [CODE_W-1:0]   rd_code;
    logic [SAMPLE_W-1:0] rd_sample;
    logic [SAMPLE_W-1:0] dev;
    logic                stop_hit;
    logic [SAMPLE_W:0]   level_sum;

    assign full      = (r_count == CW'(MAX_POINTS));
    assign rd_code   = r_rd_data[DW-1 -: CODE_W];
    assign rd_sample = r_rd_data[SAMPLE_W-1:0];
    assign dev       = (rd_sample >= r_mid_level) ? (rd_sample - r_mid_level)
                                                  : (r_mid_level - rd_sample);
    assign stop_hit  = (rd_code > r_hi_code) && (rd_code > r_lo_code);
    assign level_sum = {1'b0, r_hi_sample} + {1'b0, r_lo_sample};

    assign o_status.rd_last = ((CW'(r_addr) + CW'(1)) == r_count);

    // point store: one write port while loading, one read port while walking
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_mem[r_count[AW-1:0]] <= {i_sweep_code, i_sample};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // sweep state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hi_sample <= '0;
            r_lo_sample <= '0;
            r_hi_code   <= '0;
            r_lo_code   <= '0;
            r_dropped   <= 1'b0;
        end else if (i_cmd.emit) begin
            r_count     <= '0;
            r_hi_sample <= '0;
            r_lo_sample <= '0;
            r_hi_code   <= '0;
            r_lo_code   <= '0;
            r_dropped   <= 1'b0;
        end else if (i_cmd.load) begin
            if (full) begin
                r_dropped <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
                if (r_count == '0) begin
                    r_hi_sample <= i_sample;
                    r_lo_sample <= i_sample;
                    r_hi_code   <= i_sweep_code;
                    r_lo_code   <= i_sweep_code;
                end else if (i_sample > r_hi_sample) begin
                    r_hi_sample <= i_sample;
                    r_hi_code   <= i_sweep_code;
                end else if (i_sample < r_lo_sample) begin
                    r_lo_sample <= i_sample;
                    r_lo_code   <= i_sweep_code;
                end
            end
        end
    end

    // walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_found    <= 1'b0;
            r_stop     <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.rd_en;
            r_rd_first <= i_cmd.rd_en && (r_addr == '0);
            if (i_cmd.mid_calc) begin
                r_addr  <= '0;
                r_found <= 1'b0;
                r_stop  <= 1'b0;
            end else begin
                if (i_cmd.rd_en) begin
                    r_addr <= r_addr + AW'(1);
                end
                if (r_rd_vld && !r_stop) begin
                    if (stop_hit) begin
                        r_stop <= 1'b1;
                    end else if (r_rd_first || dev < r_best_dev) begin
                        r_found <= 1'b1;
                    end
                end
            end
        end
    end

    // mid level and chosen point payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.mid_calc) begin
            r_mid_level <= level_sum[SAMPLE_W:1];
        end
        if (r_rd_vld && !r_stop && !stop_hit && (r_rd_first || dev < r_best_dev)) begin
            r_best_dev    <= dev;
            r_pick_code   <= rd_code;
            r_pick_sample <= rd_sample;
        end
    end

    // summary output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_max_code   <= r_hi_code;
            o_min_code   <= r_lo_code;
            o_max_sample <= r_hi_sample;
            o_min_sample <= r_lo_sample;
            o_mid_code   <= r_found ? r_pick_code : '0;
            o_mid_sample <= r_found ? r_pick_sample : '0;
            o_mid_found  <= r_found;
            o_overflowed <= r_dropped;
        end
    end

endmodule
